// File: design/ssp_pkg.sv
package ssp_pkg;

  localparam int unsigned VtxW    = 10;
  localparam int unsigned WgtW    = 16;
  localparam int unsigned DistW   = 26;
  localparam int unsigned CfgIdxW = 4;

  // Infinity sits one above the largest finite distance.
  localparam logic [DistW:0] DistInf = {1'b1, {DistW{1'b0}}};

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SOURCE  = 4'd0,
    REG_REVERSE = 4'd1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]      action;
    logic [VtxW-1:0] edge_from;
    logic [VtxW-1:0] edge_to;
    logic [WgtW-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [VtxW-1:0]  vertex;
    logic [DistW-1:0] distance;
    logic             reachable;
    logic             run_done;
  } out_item_t;

  // Classified command passed from the front end to the engine.
  typedef struct packed {
    action_e         op;
    logic            ok;
    logic [VtxW-1:0] tail;
    logic [VtxW-1:0] head;
    logic [WgtW-1:0] weight;
  } cmd_t;

endpackage

// File: design/ssp_fifo.sv
module ssp_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  T     wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output T     rd_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: design/ssp_front.sv
module ssp_front import ssp_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  in_item_t item_i,
  input  logic     reverse_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  cmd_t cmd_in;
  logic from_ok, to_ok, wr_ready;

  // Range checks on the raw vertex fields.
  assign from_ok = (32'(item_i.edge_from) < MAX_VERTICES);
  assign to_ok   = (32'(item_i.edge_to) < MAX_VERTICES);

  // Classify the beat: apply the reverse setting and flag usable commands.
  always_comb begin
    cmd_in.op     = action_e'(item_i.action);
    cmd_in.weight = item_i.edge_weight;
    if (reverse_i && cmd_in.op == ACT_LOAD) begin
      cmd_in.tail = item_i.edge_to;
      cmd_in.head = item_i.edge_from;
    end else begin
      cmd_in.tail = item_i.edge_from;
      cmd_in.head = item_i.edge_to;
    end
    if (cmd_in.op == ACT_LOAD) begin
      cmd_in.ok = from_ok && to_ok;
    end else begin
      cmd_in.ok = from_ok;
    end
  end

  assign full_o = !wr_ready;

  ssp_fifo #(
    .T     (cmd_t),
    .DEPTH (4)
  ) u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_i),
    .wr_ready_o (wr_ready),
    .wr_data_i  (cmd_in),
    .rd_valid_o (cmd_valid_o),
    .rd_ready_i (cmd_ready_i),
    .rd_data_o  (cmd_o)
  );

endmodule

// File: design/ssp_engine.sv
module ssp_engine import ssp_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_EDGES    = 8192
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  cmd_t            cmd_i,
  input  logic [VtxW-1:0] src_vertex_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output out_item_t       res_o,
  output logic            busy_o
);

  localparam int unsigned VAW  = $clog2(MAX_VERTICES);
  localparam int unsigned EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned LW   = $clog2(MAX_EDGES + 1);
  localparam int unsigned LENW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EDW  = VAW + WgtW + LW;
  localparam int unsigned DDW  = DistW + 2;

  typedef enum logic [13:0] {
    S_INIT    = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_LOAD_WR = 14'b00000000000100,
    S_CLEAR   = 14'b00000000001000,
    S_RUN_CLR = 14'b00000000010000,
    S_SEED    = 14'b00000000100000,
    S_POP     = 14'b00000001000000,
    S_POP_WT  = 14'b00000010000000,
    S_UDATA   = 14'b00000100000000,
    S_EDGE    = 14'b00001000000000,
    S_EDGE_WT = 14'b00010000000000,
    S_RELAX   = 14'b00100000000000,
    S_READ_WT = 14'b01000000000000,
    S_RESULT  = 14'b10000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [VAW-1:0]   cnt_q, cnt_d;
  logic [LW-1:0]    edge_cnt_q, edge_cnt_d;
  logic [VAW-1:0]   rd_q, rd_d, wr_q, wr_d;
  logic [LENW-1:0]  len_q, len_d;
  logic [VAW-1:0]   u_q, u_d, v_q, v_d;
  logic [DistW-1:0] du_q, du_d, cand_q, cand_d;
  logic [LW-1:0]    link_q, link_d;
  cmd_t             cmd_q, cmd_d;
  out_item_t        res_q, res_d;

  // Memories: one write and one registered read port each.
  logic [LW-1:0]   head_mem [MAX_VERTICES];
  logic [EDW-1:0]  edge_mem [MAX_EDGES];
  logic [DDW-1:0]  dist_mem [MAX_VERTICES];
  logic [VAW-1:0]  ring_mem [MAX_VERTICES];

  logic            head_we, edge_we, dist_we, ring_we;
  logic [VAW-1:0]  head_wa, head_ra, dist_wa, dist_ra, ring_wa, ring_ra;
  logic [EAW-1:0]  edge_wa, edge_ra;
  logic [LW-1:0]   head_wd, head_rd_q;
  logic [EDW-1:0]  edge_wd, edge_rd_q;
  logic [DDW-1:0]  dist_wd, dist_rd_q;
  logic [VAW-1:0]  ring_wd, ring_rd_q;

  logic            sweep_last, src_ok;
  logic [DistW:0]  sum;
  logic [DistW:0]  d_read;

  assign sweep_last  = (cnt_q == VAW'(MAX_VERTICES - 1));
  assign src_ok      = (32'(src_vertex_i) < MAX_VERTICES);
  assign sum         = {1'b0, du_q} + (DistW + 1)'(edge_rd_q[LW +: WgtW]);
  assign d_read      = dist_rd_q[DistW:0];
  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;
  assign busy_o      = (state_q != S_IDLE);
  assign cmd_ready_o = (state_q == S_IDLE);

  // Sequencer for loads, clears, reads and the search itself.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    edge_cnt_d = edge_cnt_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    len_d      = len_q;
    u_d        = u_q;
    v_d        = v_q;
    du_d       = du_q;
    cand_d     = cand_q;
    link_d     = link_q;
    cmd_d      = cmd_q;
    res_d      = res_q;
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    edge_we = 1'b0; edge_wa = '0; edge_wd = '0; edge_ra = '0;
    dist_we = 1'b0; dist_wa = '0; dist_wd = '0; dist_ra = '0;
    ring_we = 1'b0; ring_wa = '0; ring_wd = '0; ring_ra = '0;
    unique case (state_q)
      S_INIT: begin
        head_we = 1'b1;
        head_wa = cnt_q;
        dist_we = 1'b1;
        dist_wa = cnt_q;
        dist_wd = {1'b0, DistInf};
        cnt_d   = cnt_q + VAW'(1);
        if (sweep_last) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          head_ra = VAW'(cmd_i.tail);
          dist_ra = VAW'(cmd_i.tail);
          unique case (cmd_i.op)
            ACT_LOAD: begin
              if (cmd_i.ok && edge_cnt_q != LW'(MAX_EDGES)) begin
                state_d = S_LOAD_WR;
              end
            end
            ACT_RUN: begin
              cnt_d   = '0;
              state_d = S_RUN_CLR;
            end
            ACT_READ: begin
              if (cmd_i.ok) begin
                state_d = S_READ_WT;
              end else begin
                res_d   = '{vertex: cmd_i.tail, distance: '0, reachable: 1'b0,
                            run_done: 1'b0};
                state_d = S_RESULT;
              end
            end
            ACT_CLEAR: begin
              cnt_d   = '0;
              state_d = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_LOAD_WR: begin
        edge_we    = 1'b1;
        edge_wa    = EAW'(edge_cnt_q);
        edge_wd    = {VAW'(cmd_q.head), cmd_q.weight, head_rd_q};
        head_we    = 1'b1;
        head_wa    = VAW'(cmd_q.tail);
        head_wd    = edge_cnt_q + LW'(1);
        edge_cnt_d = edge_cnt_q + LW'(1);
        state_d    = S_IDLE;
      end
      S_CLEAR: begin
        head_we = 1'b1;
        head_wa = cnt_q;
        cnt_d   = cnt_q + VAW'(1);
        if (sweep_last) begin
          cnt_d      = '0;
          edge_cnt_d = '0;
          state_d    = S_IDLE;
        end
      end
      S_RUN_CLR: begin
        dist_we = 1'b1;
        dist_wa = cnt_q;
        dist_wd = {1'b0, DistInf};
        cnt_d   = cnt_q + VAW'(1);
        if (sweep_last) begin
          cnt_d = '0;
          rd_d  = '0;
          wr_d  = '0;
          len_d = '0;
          if (src_ok) begin
            state_d = S_SEED;
          end else begin
            res_d   = '{vertex: src_vertex_i, distance: '0, reachable: 1'b0,
                        run_done: 1'b1};
            state_d = S_RESULT;
          end
        end
      end
      S_SEED: begin
        dist_we = 1'b1;
        dist_wa = VAW'(src_vertex_i);
        dist_wd = {1'b1, (DistW + 1)'(0)};
        ring_we = 1'b1;
        ring_wa = wr_q;
        ring_wd = VAW'(src_vertex_i);
        wr_d    = (wr_q == VAW'(MAX_VERTICES - 1)) ? '0 : wr_q + VAW'(1);
        len_d   = LENW'(1);
        state_d = S_POP;
      end
      S_POP: begin
        if (len_q == '0) begin
          res_d   = '{vertex: src_vertex_i, distance: '0, reachable: 1'b0,
                      run_done: 1'b1};
          state_d = S_RESULT;
        end else begin
          ring_ra = rd_q;
          rd_d    = (rd_q == VAW'(MAX_VERTICES - 1)) ? '0 : rd_q + VAW'(1);
          len_d   = len_q - LENW'(1);
          state_d = S_POP_WT;
        end
      end
      S_POP_WT: begin
        u_d     = ring_rd_q;
        dist_ra = ring_rd_q;
        head_ra = ring_rd_q;
        state_d = S_UDATA;
      end
      S_UDATA: begin
        // Clear the in-queue mark; the distance of u cannot drop in its own pass.
        du_d    = dist_rd_q[DistW-1:0];
        dist_we = 1'b1;
        dist_wa = u_q;
        dist_wd = {1'b0, d_read};
        link_d  = head_rd_q;
        state_d = S_EDGE;
      end
      S_EDGE: begin
        if (link_q == '0) begin
          state_d = S_POP;
        end else begin
          edge_ra = EAW'(link_q - LW'(1));
          state_d = S_EDGE_WT;
        end
      end
      S_EDGE_WT: begin
        v_d     = edge_rd_q[LW + WgtW +: VAW];
        dist_ra = edge_rd_q[LW + WgtW +: VAW];
        link_d  = edge_rd_q[LW-1:0];
        cand_d  = sum[DistW] ? '1 : sum[DistW-1:0];
        state_d = S_EDGE_WT == state_q ? S_RELAX : state_q;
      end
      S_RELAX: begin
        if (d_read > {1'b0, cand_q}) begin
          dist_we = 1'b1;
          dist_wa = v_q;
          dist_wd = {1'b1, 1'b0, cand_q};
          if (!dist_rd_q[DistW+1]) begin
            ring_we = 1'b1;
            ring_wa = wr_q;
            ring_wd = v_q;
            wr_d    = (wr_q == VAW'(MAX_VERTICES - 1)) ? '0 : wr_q + VAW'(1);
            len_d   = len_q + LENW'(1);
          end
        end
        state_d = S_EDGE;
      end
      S_READ_WT: begin
        res_d   = '{vertex: cmd_q.tail,
                    distance: d_read[DistW] ? '0 : d_read[DistW-1:0],
                    reachable: !d_read[DistW], run_done: 1'b0};
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cnt_q      <= '0;
      edge_cnt_q <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      len_q      <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      edge_cnt_q <= edge_cnt_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      len_q      <= len_d;
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    v_q    <= v_d;
    du_q   <= du_d;
    cand_q <= cand_d;
    link_q <= link_d;
    cmd_q  <= cmd_d;
    res_q  <= res_d;
  end

  // Memory ports.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_wa] <= edge_wd;
    end
    edge_rd_q <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    dist_rd_q <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    ring_rd_q <= ring_mem[ring_ra];
  end

endmodule

// File: design/single_source_shortest_path.sv
// Single-source shortest path engine (queue-based Bellman-Ford).
// Input side is a queue: a beat is taken when push is high and full is low.
// Each beat is a command: load an edge, run a search, read a distance, or
// clear the graph. Results come out of a second queue: while empty is low the
// oldest result is on out_item_o, and pop takes it.
// Configuration writes (source vertex, reverse setting) use the cfg channel,
// which is always ready; write them only while the block is idle.
// Commands wait in a four-entry queue. A run first sweeps the distance table,
// then pops queued vertices and scans each one's edges; the registered memory
// reads pace the edge scan.
// After reset the engine sweeps the list heads and distance table before it
// takes its first command; input beats still fill the command queue
// meanwhile.
// When the receiver stops popping, the two-entry result queue fills, the
// engine waits on its next result, and full rises once the command queue
// fills up.
module single_source_shortest_path import ssp_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_EDGES    = 8192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  in_item_t           in_item_i,
  output logic               empty,
  input  logic               pop,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic            rev_q;
  logic [VtxW-1:0] source_q;
  logic            cmd_valid, cmd_ready;
  cmd_t            cmd;
  logic            res_valid, res_ready, out_valid, busy;
  out_item_t       res;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q <= '0;
      rev_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_SOURCE) begin
        source_q <= cfg_data_i[VtxW-1:0];
      end else if (cfg_index_i == REG_REVERSE) begin
        rev_q <= cfg_data_i[0];
      end
    end
  end

  ssp_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (in_item_i),
    .reverse_i   (rev_q),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  ssp_engine #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .src_vertex_i (source_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .busy_o       (busy)
  );

  ssp_fifo #(
    .T     (out_item_t),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_valid),
    .wr_ready_o (res_ready),
    .wr_data_i  (res),
    .rd_valid_o (out_valid),
    .rd_ready_i (pop),
    .rd_data_o  (out_item_o)
  );

  assign empty = !out_valid;

  // The engine only offers a result while it is working on a command.
  a_res_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> busy)
    else $error("result offered while engine idle");

  // A command is only taken by an idle engine, which then offers no result.
  a_cmd_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |-> (!busy && !res_valid))
    else $error("command taken while engine busy");

  // A completed result transfer leaves the engine idle on the next cycle.
  a_res_then_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> !busy)
    else $error("engine stayed busy after delivering a result");

endmodule
